// ----- rtl/pawc_pkg.sv -----
// Package for the PID controller core with back-calculation anti-windup.
// Holds the sequencer state type, register indexes, fixed widths and the
// 48-bit state saturation helper. No dependencies.
package pawc_pkg;

   // Fixed widths of the coefficient registers and internal accumulators.
   localparam int GAIN_W         = 32;
   localparam int POLE_W         = 17;
   localparam int LIMIT_W        = 15;
   localparam int STATE_W        = 48;
   localparam int POLE_FRAC_BITS = 16;
   localparam int ACC_W          = 64;
   localparam int WIDE_W         = 96;
   localparam int MUL_W          = 33;
   localparam int PROD_W         = 2 * MUL_W;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 32;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_KP     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KI     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IEN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_POLE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KD     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_KFF    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT  = 3'd7;

   localparam logic [POLE_W-1:0]  POLE_RESET  = 17'd65536;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd32767;

   // Signed 48-bit range held in the accumulator width.
   localparam logic signed [ACC_W-1:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [ACC_W-1:0] SAT_LO = 64'shFFFF_8000_0000_0000;

   // The tracking product is clamped here; any value beyond already drives
   // the integral into saturation, exactly as the full product would.
   localparam logic signed [WIDE_W-1:0] TRK_LIMIT = WIDE_W'(1) <<< 60;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_M_P,
      ST_M_FF,
      ST_M_DG,
      ST_M_DL,
      ST_M_DH,
      ST_D_ACC,
      ST_D_SAT,
      ST_V_SUM,
      ST_LIMIT,
      ST_DIFF,
      ST_M_TL,
      ST_M_TH,
      ST_T_ACC,
      ST_T_CLAMP,
      ST_I_UPD,
      ST_DONE
   } seq_state_type;

   function automatic logic signed [STATE_W-1:0] sat48(input logic signed [ACC_W-1:0] x);
      logic signed [STATE_W-1:0] r;
      if (x > SAT_HI) begin
         r = STATE_W'(SAT_HI);
      end else if (x < SAT_LO) begin
         r = STATE_W'(SAT_LO);
      end else begin
         r = STATE_W'(x);
      end
      return r;
   endfunction

endpackage

// ----- rtl/pid_antiwindup_controller_core.sv -----
// PID controller core: error, filtered derivative on the measurement,
// feedforward, output clipping and back-calculation anti-windup.
// Depends on pawc_pkg for types, widths and the saturation helper.
//
//   channel   dir  handshake                 payload
//   req_      in   req_tvalid / req_tready   tuser: mode; tdata: reference, feedback
//   rsp_      out  rsp_tvalid / rsp_tready   tdata: control_out
//   csr_      in   csr_we                    csr_index, csr_wdata
//
// A control sample steps through the sequencer from transfer to result register, a clear
// sample goes straight to its final step; eight products on one shared 33x33 signed multiplier
// and the sums, clipping and saturation between them make up the steps of a control sample.
// The input is ready only while the sequencer is idle; a result still waiting
// on the output stalls the next sample in its last step, not its transfer.
// Reset is synchronous and returns registers and controller state at once.
module pid_antiwindup_controller_core #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 16,
   localparam int REQ_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_W-1:0]                  req_tdata,  // reference, feedback
   input  logic [0:0]                        req_tuser,  // mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_W-1:0]                  rsp_tdata,  // control_out
   input  logic                              csr_we,
   input  logic [pawc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pawc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pawc_pkg::*;

   localparam int SW  = SAMPLE_WIDTH;
   localparam int CFB = COEF_FRAC_BITS;
   localparam logic [31:0] LIM_MAX = 32'((64'd1 << (SW - 1)) - 64'd1);

   // Configuration registers.
   logic signed [GAIN_W-1:0] kp_ff, ki_ff, kt_ff, kd_ff, kff_ff;
   logic                     ien_ff;
   logic [POLE_W-1:0]        pole_ff;
   logic [LIMIT_W-1:0]       lim_ff;

   // Controller state and sequencer.
   seq_state_type            state_ff, state_in;
   logic                     primed_ff, primed_in;
   logic signed [SW-1:0]     prev_ff, prev_in;
   logic signed [STATE_W-1:0] int_ff, int_in;
   logic signed [STATE_W-1:0] der_ff, der_in;

   // Working registers of one sample.
   logic signed [SW-1:0]     refr_ff, refr_in;
   logic signed [SW:0]       err_ff, err_in;
   logic signed [SW:0]       ydiff_ff, ydiff_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [WIDE_W-1:0] wide_ff, wide_in;
   logic signed [ACC_W-1:0]  v_ff, v_in;
   logic signed [ACC_W-1:0]  dg_ff, dg_in;
   logic signed [ACC_W-1:0]  mi_ff, mi_in;
   logic signed [ACC_W-1:0]  u_ff, u_in;
   logic signed [ACC_W-1:0]  diff_ff, diff_in;
   logic signed [ACC_W-1:0]  mt_ff, mt_in;
   logic [SW-1:0]            res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]            rsp_data_ff, rsp_data_in;

   // Shared multiplier operands.
   logic signed [MUL_W-1:0]  mul_a, mul_b;

   logic signed [SW-1:0]     req_ref, req_fbk;
   logic signed [ACC_W-1:0]  psh, dsh, limq;
   logic signed [WIDE_W-1:0] tsh;
   logic [31:0]              lim_eff;

   assign req_ref = signed'(req_tdata[SW-1:0]);
   assign req_fbk = signed'(req_tdata[2*SW-1:SW]);

   assign psh     = ACC_W'(prod_ff >>> CFB);
   assign dsh     = ACC_W'(wide_ff >>> POLE_FRAC_BITS);
   assign tsh     = wide_ff >>> CFB;
   assign lim_eff = (32'(lim_ff) > LIM_MAX) ? LIM_MAX : 32'(lim_ff);
   assign limq    = signed'(ACC_W'(lim_eff) << CFB);

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= '0;
         ki_ff   <= '0;
         kt_ff   <= '0;
         ien_ff  <= 1'b0;
         pole_ff <= POLE_RESET;
         kd_ff   <= '0;
         kff_ff  <= '0;
         lim_ff  <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_KP:    kp_ff   <= signed'(csr_wdata[GAIN_W-1:0]);
            REG_KI:    ki_ff   <= signed'(csr_wdata[GAIN_W-1:0]);
            REG_KT:    kt_ff   <= signed'(csr_wdata[GAIN_W-1:0]);
            REG_IEN:   ien_ff  <= csr_wdata[0];
            REG_POLE:  pole_ff <= csr_wdata[POLE_W-1:0];
            REG_KD:    kd_ff   <= signed'(csr_wdata[GAIN_W-1:0]);
            REG_KFF:   kff_ff  <= signed'(csr_wdata[GAIN_W-1:0]);
            REG_LIMIT: lim_ff  <= csr_wdata[LIMIT_W-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         primed_ff    <= 1'b0;
         prev_ff      <= '0;
         int_ff       <= '0;
         der_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         prev_ff      <= prev_in;
         int_ff       <= int_in;
         der_ff       <= der_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      refr_ff     <= refr_in;
      err_ff      <= err_in;
      ydiff_ff    <= ydiff_in;
      prod_ff     <= prod_in;
      wide_ff     <= wide_in;
      v_ff        <= v_in;
      dg_ff       <= dg_in;
      mi_ff       <= mi_in;
      u_ff        <= u_in;
      diff_ff     <= diff_in;
      mt_ff       <= mt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Each step issues at most one product and consumes the one issued in
   // the step before it.
   always_comb begin
      state_in     = state_ff;
      primed_in    = primed_ff;
      prev_in      = prev_ff;
      int_in       = int_ff;
      der_in       = der_ff;
      refr_in      = refr_ff;
      err_in       = err_ff;
      ydiff_in     = ydiff_ff;
      wide_in      = wide_ff;
      v_in         = v_ff;
      dg_in        = dg_ff;
      mi_in        = mi_ff;
      u_in         = u_ff;
      diff_in      = diff_ff;
      mt_in        = mt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0]) begin
                  primed_in = 1'b0;
                  prev_in   = '0;
                  int_in    = '0;
                  der_in    = '0;
                  res_in    = '0;
                  state_in  = ST_DONE;
               end else begin
                  refr_in   = req_ref;
                  err_in    = (SW + 1)'(req_ref) - (SW + 1)'(req_fbk);
                  ydiff_in  = primed_ff ? (SW + 1)'(req_fbk) - (SW + 1)'(prev_ff) : '0;
                  prev_in   = req_fbk;
                  primed_in = 1'b1;
                  state_in  = ST_M_P;
               end
            end
         end
         ST_M_P: begin
            mul_a    = MUL_W'(err_ff);
            mul_b    = MUL_W'(kp_ff);
            state_in = ST_M_FF;
         end
         ST_M_FF: begin
            mul_a    = MUL_W'(refr_ff);
            mul_b    = MUL_W'(kff_ff);
            v_in     = psh + ACC_W'(int_ff);
            state_in = ST_M_DG;
         end
         ST_M_DG: begin
            mul_a    = MUL_W'(ydiff_ff);
            mul_b    = MUL_W'(kd_ff);
            v_in     = v_ff + psh;
            state_in = ST_M_DL;
         end
         ST_M_DL: begin
            // Low word of the derivative state times the pole.
            mul_a    = signed'({1'b0, der_ff[31:0]});
            mul_b    = signed'({16'b0, pole_ff});
            dg_in    = psh;
            state_in = ST_M_DH;
         end
         ST_M_DH: begin
            mul_a    = MUL_W'(signed'(der_ff[STATE_W-1:32]));
            mul_b    = signed'({16'b0, pole_ff});
            wide_in  = WIDE_W'(prod_ff);
            state_in = ST_D_ACC;
         end
         ST_D_ACC: begin
            mul_a    = MUL_W'(err_ff);
            mul_b    = MUL_W'(ki_ff);
            wide_in  = wide_ff + signed'({prod_ff[ACC_W-1:0], 32'b0});
            state_in = ST_D_SAT;
         end
         ST_D_SAT: begin
            der_in   = sat48(dsh - dg_ff);
            mi_in    = ACC_W'(int_ff) + psh;
            state_in = ST_V_SUM;
         end
         ST_V_SUM: begin
            v_in     = v_ff + ACC_W'(der_ff);
            state_in = ST_LIMIT;
         end
         ST_LIMIT: begin
            if (v_ff > limq) begin
               u_in = limq;
            end else if (v_ff < -limq) begin
               u_in = -limq;
            end else begin
               u_in = v_ff;
            end
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in  = u_ff - v_ff;
            state_in = ST_M_TL;
         end
         ST_M_TL: begin
            mul_a    = signed'({1'b0, diff_ff[31:0]});
            mul_b    = MUL_W'(kt_ff);
            state_in = ST_M_TH;
         end
         ST_M_TH: begin
            mul_a    = MUL_W'(signed'(diff_ff[ACC_W-1:32]));
            mul_b    = MUL_W'(kt_ff);
            wide_in  = WIDE_W'(prod_ff);
            state_in = ST_T_ACC;
         end
         ST_T_ACC: begin
            wide_in  = wide_ff + signed'({prod_ff[ACC_W-1:0], 32'b0});
            state_in = ST_T_CLAMP;
         end
         ST_T_CLAMP: begin
            if (tsh > TRK_LIMIT) begin
               mt_in = ACC_W'(TRK_LIMIT);
            end else if (tsh < -TRK_LIMIT) begin
               mt_in = ACC_W'(-TRK_LIMIT);
            end else begin
               mt_in = ACC_W'(tsh);
            end
            state_in = ST_I_UPD;
         end
         ST_I_UPD: begin
            int_in   = ien_ff ? sat48(mi_ff + mt_ff) : '0;
            res_in   = u_ff[CFB +: SW];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   // A clear transfer empties the controller state at once.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0]) |=>
         (int_ff == '0 && der_ff == '0 && !primed_ff && state_ff == ST_DONE))
      else $error("clear transfer did not empty the controller state");

   // A control transfer arms the measurement difference for the next sample.
   a_primed_after_step: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser[0]) |=>
         (primed_ff && state_ff == ST_M_P))
      else $error("control transfer did not prime the sequencer");

   // With the integral disabled its update always lands on zero.
   a_integral_disabled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_I_UPD && !ien_ff) |=> (int_ff == '0))
      else $error("integral not held at zero while disabled");

   // A new result appears only out of the final sequencer step.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the final step");
`endif

endmodule

// ----- dv/tb.sv -----
// Testbench for pid_antiwindup_controller_core: directed and random control samples and
// clear items are checked against a behavioral PID model across many register settings.
// Depends on pawc_pkg and the core RTL; it needs no files or arguments.
module tb;
   import pawc_pkg::*;

   localparam int SAMPLE_W       = 16;
   localparam int FRAC           = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 112;
   localparam logic MODE_STEP    = 1'b0;
   localparam logic MODE_CLEAR   = 1'b1;
   localparam longint PROD_LIM   = 64'sd1 <<< 62;
   localparam longint STATE_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint STATE_MIN  = -STATE_MAX - 1;

   // Predicts the control output of every accepted sample and checks the results in order.
   class control_scoreboard;
      logic signed [GAIN_W-1:0]   kp, ki_ts, kt, kd, kff;
      logic                       int_en;
      logic [POLE_W-1:0]          pole;
      logic [LIMIT_W-1:0]         limit;
      bit                         primed;
      logic signed [SAMPLE_W-1:0] last_meas;
      longint                     int_sum, der_sum;
      logic signed [SAMPLE_W-1:0] pending_out[$];
      int                         errors;

      function new();
         kp = '0;
         ki_ts = '0;
         kt = '0;
         kd = '0;
         kff = '0;
         int_en = 1'b0;
         pole = POLE_RESET;
         limit = LIMIT_RESET;
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         primed = 1'b0;
         last_meas = '0;
         int_sum = 0;
         der_sum = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_KP: kp = data;
            REG_KI: ki_ts = data;
            REG_KT: kt = data;
            REG_IEN: int_en = data[0];
            REG_POLE: pole = data[POLE_W-1:0];
            REG_KD: kd = data;
            REG_KFF: kff = data;
            REG_LIMIT: limit = data[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      // floor(a * b / 2^FRAC); large operands are split so that the product can be
      // clamped to +-2^62 without overflowing.
      function longint scaled_product(longint a, longint b);
         longint hi, lo, ah, bb;
         if (a == 0 || b == 0) return 0;
         if (a > -(64'sd1 <<< 32) && a < (64'sd1 <<< 32)) return (a * b) >>> FRAC;
         hi = a >>> FRAC;
         lo = a & ((64'sd1 <<< FRAC) - 1);
         ah = (hi < 0) ? -hi : hi;
         bb = (b < 0) ? -b : b;
         if (ah > PROD_LIM / bb) return ((hi < 0) != (b < 0)) ? -PROD_LIM : PROD_LIM;
         return hi * b + ((lo * b) >>> FRAC);
      endfunction

      function longint sat_state(longint x);
         if (x > STATE_MAX) return STATE_MAX;
         if (x < STATE_MIN) return STATE_MIN;
         return x;
      endfunction

      function void note_sample(logic mode, logic signed [SAMPLE_W-1:0] setpoint,
                                logic signed [SAMPLE_W-1:0] measured);
         longint err, ydiff, dhi, dlo, v, u, limq;
         logic signed [SAMPLE_W-1:0] out;
         if (mode == MODE_CLEAR) begin
            clear_state();
            pending_out.push_back('0);
            return;
         end
         err = longint'(setpoint) - longint'(measured);
         ydiff = primed ? longint'(measured) - longint'(last_meas) : 0;
         last_meas = measured;
         primed = 1'b1;

         // The pole is Q1.16, so the derivative state is split into whole and fraction.
         dhi = der_sum >>> POLE_FRAC_BITS;
         dlo = der_sum & 64'hFFFF;
         der_sum = sat_state(dhi * longint'(pole) + ((dlo * longint'(pole)) >>> POLE_FRAC_BITS)
                             - scaled_product(ydiff, kd));

         v = scaled_product(err, kp) + int_sum + der_sum
             + scaled_product(longint'(setpoint), kff);
         limq = longint'(limit) <<< FRAC;
         if (v > limq) u = limq;
         else if (v < -limq) u = -limq;
         else u = v;

         if (int_en)
            int_sum = sat_state(int_sum + scaled_product(err, ki_ts)
                                + scaled_product(u - v, kt));
         else
            int_sum = 0;

         out = SAMPLE_W'(u >>> FRAC);
         pending_out.push_back(out);
      endfunction

      function void check_output(logic [SAMPLE_W-1:0] actual);
         logic signed [SAMPLE_W-1:0] want;
         if (pending_out.size() == 0) begin
            $error("control_out: unexpected transfer, expected none, actual %0d",
                   $signed(actual));
            errors++;
            return;
         end
         want = pending_out.pop_front();
         if (actual !== want) begin
            $error("control_out mismatch: expected %0d, actual %0d", want, $signed(actual));
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata   = '0;
   logic [0:0]            req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = REG_KP;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles  = 0;

   control_scoreboard sb = new();

   pid_antiwindup_controller_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // reference, feedback
      .req_tuser  (req_tuser),   // mode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // control_out
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_output(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // Leaves tvalid high after the transfer so that back-to-back samples need no gap.
   task automatic send_item(input logic mode, input logic signed [SAMPLE_W-1:0] setpoint,
                            input logic signed [SAMPLE_W-1:0] measured);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {measured, setpoint};
      do @(posedge clock); while (!req_tready);
      sb.note_sample(mode, setpoint, measured);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_out.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(idx, data);
   endtask

   task automatic apply_config(input logic [31:0] kp, ki, kt, ien, pole, kd, kff, lim);
      write_reg(REG_KP, kp);
      write_reg(REG_KI, ki);
      write_reg(REG_KT, kt);
      write_reg(REG_IEN, ien);
      write_reg(REG_POLE, pole);
      write_reg(REG_KD, kd);
      write_reg(REG_KFF, kff);
      write_reg(REG_LIMIT, lim);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly gains of a few units so the loop stays out of saturation for a while.
   function automatic logic [31:0] random_gain();
      case ($urandom_range(9))
         0: return 32'h0;
         1: return $urandom();
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3, 4, 5: return 32'($urandom_range(1 << 18)) - 32'(1 << 17);
         default: return 32'($urandom_range(1 << 21)) - 32'(1 << 20);
      endcase
   endfunction

   task automatic random_config();
      logic [31:0] pole_val, lim_val, ien_val;
      case ($urandom_range(4))
         0: pole_val = 32'(POLE_RESET);
         1: pole_val = 32'h0;
         2: pole_val = 32'h0001_FFFF;
         3: pole_val = $urandom_range(65536);
         default: pole_val = $urandom();
      endcase
      case ($urandom_range(4))
         0: lim_val = 32'h0;
         1: lim_val = 32'(LIMIT_RESET);
         2: lim_val = $urandom_range(1, 300);
         3: lim_val = $urandom();
         default: lim_val = $urandom_range(32767);
      endcase
      ien_val = $urandom();
      ien_val[0] = ($urandom_range(3) != 0);
      apply_config(random_gain(), random_gain(), random_gain(), ien_val, pole_val,
                   random_gain(), random_gain(), lim_val);
   endtask

   initial begin
      int plant, target, pick;
      logic signed [SAMPLE_W-1:0] setpoint, measured;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // All gains are zero after reset.
      send_item(MODE_STEP, 16'sd100, 16'sd50);
      wait_idle();

      apply_config(32'h0001_0000, 32'h0000_1000, 32'h0000_8000, 32'h1, 32'h0000_C000,
                   32'h0002_0000, 32'h0000_4000, 32'd1000);
      send_item(MODE_STEP, 16'sd0, 16'sd0);
      send_item(MODE_STEP, 16'sh7FFF, 16'sh8000);
      send_item(MODE_STEP, 16'sh8000, 16'sh7FFF);
      send_item(MODE_STEP, 16'sd200, 16'sd100);
      send_item(MODE_STEP, 16'sd200, 16'sd150);
      send_item(MODE_CLEAR, 16'shFFFF, 16'shFFFF);
      // The first sample after a clear sees no measurement change.
      send_item(MODE_STEP, 16'sd200, 16'sd180);
      send_item(MODE_STEP, -16'sd5, 16'sd7);
      wait_idle();

      // Largest gains and a pole above one, so products clamp and the derivative grows.
      apply_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h0001_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'(LIMIT_RESET));
      send_item(MODE_STEP, 16'sh7FFF, 16'sh8000);
      send_item(MODE_STEP, 16'sh8000, 16'sh7FFF);
      send_item(MODE_STEP, 16'sd1, 16'sd0);
      send_item(MODE_STEP, -16'sd1, 16'sd1);
      wait_idle();

      apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_item(MODE_STEP, 16'sd1234, -16'sd4321);
      send_item(MODE_STEP, 16'sh8000, 16'sh8000);
      send_item(MODE_CLEAR, 16'sh0000, 16'sh0000);
      send_item(MODE_STEP, 16'sh7FFF, 16'sh7FFF);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         random_config();
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 65; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 65; end
            default: begin req_idle_pct = 20; rsp_stall_pct = 20; end
         endcase
         target = int'($urandom_range(8000)) - 4000;
         plant = target + int'($urandom_range(2000)) - 1000;
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 2) wait_idle();
            if (pick < 7) begin
               send_item(MODE_CLEAR, 16'($urandom()), 16'($urandom()));
            end else if (pick < 22) begin
               send_item(MODE_STEP, 16'($urandom()), 16'($urandom()));
            end else if (pick < 27) begin
               setpoint = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
               measured = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
               send_item(MODE_STEP, setpoint, measured);
            end else begin
               // A crude plant that follows the setpoint, so the loop runs a real trajectory.
               if (pick < 32) target = int'($urandom_range(8000)) - 4000;
               plant = plant + (target - plant) / 8 + int'($urandom_range(128)) - 64;
               if (plant > 32767) plant = 32767;
               if (plant < -32768) plant = -32768;
               send_item(MODE_STEP, 16'(target), 16'(plant));
            end
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/pawc_pkg.sv
rtl/pid_antiwindup_controller_core.sv
dv/tb.sv
